// ===== rtl/core/i2car_pkg.sv =====
`timescale 1ns / 1ps

package i2car_pkg;

  // bus event codes carried in the action field
  typedef enum logic [1:0] {
    ACT_ADDR = 2'd0,
    ACT_RX   = 2'd1,
    ACT_TX   = 2'd2,
    ACT_STOP = 2'd3
  } action_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_VERSION_MAJOR   = 2'd0,
    CFG_VERSION_MINOR   = 2'd1,
    CFG_VERSION_EXTRA_A = 2'd2,
    CFG_VERSION_EXTRA_B = 2'd3
  } cfg_index_e;

  localparam int unsigned ActionW   = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned SwitchW   = 6;
  localparam int unsigned CfgIndexW = 2;

  // register map addresses
  localparam logic [ByteW-1:0] ADDR_VERSION_MAJOR   = 8'd0;
  localparam logic [ByteW-1:0] ADDR_VERSION_MINOR   = 8'd1;
  localparam logic [ByteW-1:0] ADDR_VERSION_EXTRA_A = 8'd2;
  localparam logic [ByteW-1:0] ADDR_VERSION_EXTRA_B = 8'd3;
  localparam logic [ByteW-1:0] ADDR_FILTER          = 8'd4;
  localparam logic [ByteW-1:0] ADDR_SWITCH_CFG      = 8'd5;
  localparam logic [ByteW-1:0] ADDR_TOGGLE          = 8'd6;

  // toggle register read pattern
  localparam logic [ByteW-1:0] TOGGLE_FIRST  = 8'hAA;
  localparam logic [ByteW-1:0] TOGGLE_SECOND = 8'h55;

  // one result item
  typedef struct packed {
    logic               tx_load;
    logic [ByteW-1:0]   tx_byte;
    logic [SwitchW-1:0] switch_bits;
    logic [ByteW-1:0]   filter_mode;
  } result_t;

endpackage

// ===== rtl/core/i2car_in_if.sv =====
`timescale 1ns / 1ps

interface i2car_in_if;
  logic                         valid;
  logic                         ready;
  logic [i2car_pkg::ActionW-1:0] action;
  logic [i2car_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

// ===== rtl/core/i2car_out_if.sv =====
`timescale 1ns / 1ps

interface i2car_out_if;
  logic                          valid;
  logic                          ready;
  logic                          tx_load;
  logic [i2car_pkg::ByteW-1:0]   tx_byte;
  logic [i2car_pkg::SwitchW-1:0] switch_bits;
  logic [i2car_pkg::ByteW-1:0]   filter_mode;

  modport source (
    output valid, output tx_load, output tx_byte, output switch_bits,
    output filter_mode, input ready
  );
  modport sink (
    input valid, input tx_load, input tx_byte, input switch_bits,
    input filter_mode, output ready
  );
endinterface

// ===== rtl/core/i2car_regmap.sv =====
`timescale 1ns / 1ps

module i2car_regmap (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [i2car_pkg::ActionW-1:0]   action_i,
  input  logic [i2car_pkg::ByteW-1:0]     rx_byte_i,
  input  logic                            cfg_we_i,
  input  logic [i2car_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [i2car_pkg::ByteW-1:0]     cfg_wdata_i,
  output i2car_pkg::result_t              result_o
);

  logic [i2car_pkg::ByteW-1:0] ver_major_q, ver_minor_q, ver_extra_a_q, ver_extra_b_q;
  logic [i2car_pkg::ByteW-1:0] ptr_q, ptr_d;
  logic                        ptr_valid_q, ptr_valid_d;
  logic [i2car_pkg::ByteW-1:0] filter_q, filter_d;
  logic [i2car_pkg::ByteW-1:0] switch_cfg_q, switch_cfg_d;
  logic                        toggle_q, toggle_d;

  logic [i2car_pkg::ByteW-1:0] ptr_inc;
  logic [i2car_pkg::ByteW-1:0] rd_addr;
  logic [i2car_pkg::ByteW-1:0] rd_data;
  logic                        rd_en;
  logic                        wr_en;

  function automatic logic [i2car_pkg::ByteW-1:0] i2c_inc(input logic [i2car_pkg::ByteW-1:0] v);
    i2c_inc = v + 8'd1;
  endfunction

  assign ptr_inc = i2c_inc(ptr_q);

  // decode the bus event
  always_comb begin
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = ptr_inc;
    ptr_d       = ptr_q;
    ptr_valid_d = ptr_valid_q;
    case (action_i)
      i2car_pkg::ACT_ADDR: begin
        ptr_valid_d = 1'b0;
      end
      i2car_pkg::ACT_RX: begin
        if (!ptr_valid_q) begin
          // first byte sets the pointer and preloads its data
          ptr_d       = rx_byte_i;
          ptr_valid_d = 1'b1;
          rd_addr     = rx_byte_i;
          rd_en       = 1'b1;
        end else begin
          wr_en = 1'b1;
          ptr_d = ptr_inc;
        end
      end
      i2car_pkg::ACT_TX: begin
        ptr_d = ptr_inc;
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // read mux, toggle flips on each read of the toggle register
  always_comb begin
    toggle_d = toggle_q;
    case (rd_addr)
      i2car_pkg::ADDR_VERSION_MAJOR:   rd_data = ver_major_q;
      i2car_pkg::ADDR_VERSION_MINOR:   rd_data = ver_minor_q;
      i2car_pkg::ADDR_VERSION_EXTRA_A: rd_data = ver_extra_a_q;
      i2car_pkg::ADDR_VERSION_EXTRA_B: rd_data = ver_extra_b_q;
      i2car_pkg::ADDR_FILTER:          rd_data = filter_q;
      i2car_pkg::ADDR_SWITCH_CFG:      rd_data = switch_cfg_q;
      i2car_pkg::ADDR_TOGGLE: begin
        rd_data = toggle_q ? i2car_pkg::TOGGLE_SECOND : i2car_pkg::TOGGLE_FIRST;
        if (rd_en) begin
          toggle_d = ~toggle_q;
        end
      end
      default:                         rd_data = '0;
    endcase
  end

  // writable registers
  always_comb begin
    filter_d     = filter_q;
    switch_cfg_d = switch_cfg_q;
    if (wr_en && (ptr_q == i2car_pkg::ADDR_FILTER)) begin
      filter_d = rx_byte_i;
    end
    if (wr_en && (ptr_q == i2car_pkg::ADDR_SWITCH_CFG)) begin
      switch_cfg_d = rx_byte_i;
    end
  end

  // result of this event
  always_comb begin
    result_o.tx_load     = rd_en;
    result_o.tx_byte     = rd_en ? rd_data : '0;
    result_o.switch_bits = switch_cfg_d[i2car_pkg::SwitchW-1:0];
    result_o.filter_mode = filter_d;
  end

  // state update on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q        <= '0;
      ptr_valid_q  <= 1'b0;
      filter_q     <= '0;
      switch_cfg_q <= '0;
      toggle_q     <= 1'b0;
    end else if (step_i) begin
      ptr_q        <= ptr_d;
      ptr_valid_q  <= ptr_valid_d;
      filter_q     <= filter_d;
      switch_cfg_q <= switch_cfg_d;
      toggle_q     <= toggle_d;
    end
  end

  // version bytes from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_major_q   <= '0;
      ver_minor_q   <= '0;
      ver_extra_a_q <= '0;
      ver_extra_b_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        i2car_pkg::CFG_VERSION_MAJOR:   ver_major_q   <= cfg_wdata_i;
        i2car_pkg::CFG_VERSION_MINOR:   ver_minor_q   <= cfg_wdata_i;
        i2car_pkg::CFG_VERSION_EXTRA_A: ver_extra_a_q <= cfg_wdata_i;
        i2car_pkg::CFG_VERSION_EXTRA_B: ver_extra_b_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/i2c_autoinc_register_slave.sv =====
`timescale 1ns / 1ps

// Byte-level register map for an I2C slave with an auto-incrementing pointer.
// in_if carries one bus event per item (address match, received byte,
// transmit ready, stop) with the received byte. out_if carries one result
// item per event: a transmit load strobe with its byte, and the current
// switch bits and filter option.
// State updates at the accepting edge and the result sits in the output
// register from the next cycle; one item can be taken every cycle while the
// receiver keeps taking results.
// The output register is the only buffer: a new item is taken while the
// register is empty or its result is taken in the same cycle. When the
// receiver stalls, the result holds and in_if.ready drops until it is taken.
// Reset clears the pointer, the pointer-valid flag, the filter option, the
// switch configuration, the toggle flag and the version bytes; no result is pending.
// Version bytes use cfg_we_i / cfg_index_i / cfg_wdata_i; the user must
// write them only while no item is in flight; the block does not enforce it.
module i2c_autoinc_register_slave (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  i2car_in_if.sink                        in_if,
  i2car_out_if.source                     out_if,
  input  logic                            cfg_we_i,
  input  logic [i2car_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [i2car_pkg::ByteW-1:0]     cfg_wdata_i
);

  logic               in_accept;
  logic               out_valid_q;
  i2car_pkg::result_t out_res_q;
  i2car_pkg::result_t step_res;

  // take an item while the output register is free or draining
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;

  i2car_regmap u_regmap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_accept),
    .action_i    (in_if.action),
    .rx_byte_i   (in_if.rx_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (step_res)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      out_valid_q <= in_if.valid;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_res_q <= step_res;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.tx_load     = out_res_q.tx_load;
  assign out_if.tx_byte     = out_res_q.tx_byte;
  assign out_if.switch_bits = out_res_q.switch_bits;
  assign out_if.filter_mode = out_res_q.filter_mode;

endmodule

// ===== rtl/core/i2car_checker.sv =====
`timescale 1ns / 1ps

module i2car_checker (
  input logic         clk_i,
  input logic         rst_ni,
  i2car_in_if.sink    in_if,
  i2car_out_if.source out_if
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid)
    else $error("result dropped while stalled");

  // every accepted item shows a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> out_if.valid)
    else $error("accepted item gave no result");

  // an empty output side always takes an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("block not ready with empty output");

  // no transmit load means a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.tx_load |-> out_if.tx_byte == '0)
    else $error("tx byte set without load");

endmodule

bind i2c_autoinc_register_slave i2car_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_if  (in_if),
  .out_if (out_if)
);
